>>> hw/rtl/two_stage_query_escaper_defines.svh
// ----------------------------------------------------------------------------
// two_stage_query_escaper_defines.svh
// Assertion macros shared by the query escaper RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_STAGE_QUERY_ESCAPER_DEFINES_SVH
`define TWO_STAGE_QUERY_ESCAPER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSQE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsqe: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TSQE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsqe: next-cycle check failed");

`endif

>>> hw/rtl/tsqe_pkg.sv
// ----------------------------------------------------------------------------
// tsqe_pkg
// Constants, register map and lookup functions of the query escaper.
// ----------------------------------------------------------------------------
package tsqe_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned DataW    = 64;
	localparam int unsigned AddrW    = 6;
	localparam int unsigned ExcW     = 21;
	localparam int unsigned SetSize  = 20;
	localparam int unsigned MaskBits = 256;

	localparam logic [ByteW-1:0] EscChar = 8'h5C;

	// Register indexes (byte address = 8 * index)
	localparam logic [2:0] RegExcMask = 3'd0;
	localparam logic [2:0] RegMask0   = 3'd1;
	localparam logic [2:0] RegMask1   = 3'd2;
	localparam logic [2:0] RegMask2   = 3'd3;
	localparam logic [2:0] RegMask3   = 3'd4;

	localparam logic [ExcW-1:0]  ExcReset   = '0;
	localparam logic [DataW-1:0] Mask0Reset = 64'd17179869184;
	localparam logic [DataW-1:0] Mask1Reset = 64'd268435456;
	localparam logic [DataW-1:0] Mask2Reset = '0;
	localparam logic [DataW-1:0] Mask3Reset = '0;

	// Query-syntax set; entry i pairs with exception bit i
	localparam logic [ByteW-1:0] SyntaxSet [SetSize] = '{
		8'h2B, 8'h2D, 8'h26, 8'h7C, 8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B,
		8'h5D, 8'h5E, 8'h22, 8'h7E, 8'h2A, 8'h3F, 8'h3A, 8'h5C, 8'h2F, 8'h20
	};

	// One bit per set entry that equals the byte
	function automatic logic [SetSize-1:0] syntax_match(input logic [ByteW-1:0] c);
		logic [SetSize-1:0] m;
		m = '0;
		for (int i = 0; i < SetSize; i++) begin
			m[i] = (SyntaxSet[i] == c);
		end
		return m;
	endfunction

	// Second-stage mask bit for a byte value
	function automatic logic mask_bit(input logic [MaskBits-1:0] mask,
			input logic [ByteW-1:0] c);
		return mask[c];
	endfunction

endpackage

>>> hw/rtl/tsqe_in_if.sv
// ----------------------------------------------------------------------------
// tsqe_in_if
// Input channel of the query escaper: one text byte per transfer.
// ----------------------------------------------------------------------------
interface tsqe_in_if;
	import tsqe_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);

endinterface

>>> hw/rtl/tsqe_out_if.sv
// ----------------------------------------------------------------------------
// tsqe_out_if
// Output channel of the query escaper: one escaped byte per transfer.
// ----------------------------------------------------------------------------
interface tsqe_out_if;
	import tsqe_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] out_byte;
	logic             run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink (input valid, input out_byte, input run_last, output ready);

endinterface

>>> hw/rtl/two_stage_query_escaper.sv
// ----------------------------------------------------------------------------
// two_stage_query_escaper
// Two-stage backslash escaper for query text, one input byte per transfer.
// ----------------------------------------------------------------------------
// Each input byte expands to 1 to 4 output bytes: 0 to 3 backslashes followed
// by the byte itself, with run_last set on the byte itself. The output is
// driven from a single result register that sends one byte per cycle while
// out_ch.ready is high; an input byte holds it until its last byte is sent,
// so a stream with nothing to escape runs at one byte per cycle while the
// output is ready. An input transfer passes the input register, then the
// result register. Registers sit on an APB-style port with 64-bit data at
// byte addresses 0 (exception mask), 8, 16, 24, 32 (second-stage mask words);
// pready is always high, writes to other addresses are dropped and read as 0.
// ----------------------------------------------------------------------------
`include "two_stage_query_escaper_defines.svh"

module two_stage_query_escaper (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tsqe_pkg::AddrW-1:0] paddr,
	input  logic [tsqe_pkg::DataW-1:0] pwdata,
	output logic [tsqe_pkg::DataW-1:0] prdata,
	output logic                       pready,
	tsqe_in_if.sink                    in_ch,
	tsqe_out_if.source                 out_ch
);
	import tsqe_pkg::*;

	logic [ExcW-1:0]  exc_q;
	logic [DataW-1:0] mask0_q, mask1_q, mask2_q, mask3_q;
	logic [2:0]       reg_idx;
	logic             cfg_wr;

	logic             v_s1;
	logic [ByteW-1:0] byte_s1;
	logic             v_s2;
	logic [ByteW-1:0] byte_s2;
	logic [1:0]       rem_s2;

	logic [MaskBits-1:0] mask_all;
	logic                esc1, esc2_bs, esc2_c;
	logic [1:0]          n_bs;
	logic                out_done, adv_s1;

	// Register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[AddrW-1:3];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exc_q   <= ExcReset;
			mask0_q <= Mask0Reset;
			mask1_q <= Mask1Reset;
			mask2_q <= Mask2Reset;
			mask3_q <= Mask3Reset;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				RegExcMask: exc_q   <= pwdata[ExcW-1:0];
				RegMask0:   mask0_q <= pwdata;
				RegMask1:   mask1_q <= pwdata;
				RegMask2:   mask2_q <= pwdata;
				RegMask3:   mask3_q <= pwdata;
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegExcMask: prdata = DataW'(exc_q);
			RegMask0:   prdata = mask0_q;
			RegMask1:   prdata = mask1_q;
			RegMask2:   prdata = mask2_q;
			RegMask3:   prdata = mask3_q;
			default:    prdata = '0;
		endcase
	end

	// Handshake: the result register frees up on the transfer of its last byte
	assign out_done    = v_s2 && out_ch.ready && (rem_s2 == 2'd0);
	assign adv_s1      = v_s1 && (!v_s2 || out_done);
	assign in_ch.ready = !v_s1 || adv_s1;

	// Count backslashes: stage one, stage two on that backslash, stage two on byte
	assign mask_all = {mask3_q, mask2_q, mask1_q, mask0_q};
	assign esc1     = |(syntax_match(byte_s1) & ~exc_q[SetSize-1:0]);
	assign esc2_bs  = esc1 && mask_bit(mask_all, EscChar);
	assign esc2_c   = mask_bit(mask_all, byte_s1);
	assign n_bs     = {1'b0, esc1} + {1'b0, esc2_bs} + {1'b0, esc2_c};

	// Advance valid and count through both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			rem_s2 <= 2'd0;
		end else begin
			if (in_ch.ready) begin
				v_s1 <= in_ch.valid;
			end
			if (adv_s1) begin
				v_s2   <= 1'b1;
				rem_s2 <= n_bs;
			end else if (out_done) begin
				v_s2 <= 1'b0;
			end else if (v_s2 && out_ch.ready) begin
				rem_s2 <= rem_s2 - 2'd1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
		end
		if (adv_s1) begin
			byte_s2 <= byte_s1;
		end
	end

	// Backslashes first, then the byte itself flagged as last
	assign out_ch.valid    = v_s2;
	assign out_ch.run_last = (rem_s2 == 2'd0);
	assign out_ch.out_byte = (rem_s2 == 2'd0) ? byte_s2 : EscChar;

	// Checks
	`TSQE_ASSERT_NOW(a_in_needs_room, in_ch.valid && in_ch.ready && v_s1, adv_s1)
	`TSQE_ASSERT_NEXT(a_rem_counts_down, v_s2 && out_ch.ready && (rem_s2 != 2'd0), v_s2 && (rem_s2 == 2'($past(rem_s2) - 2'd1)))
	`TSQE_ASSERT_NEXT(a_last_frees_s2, out_done && !adv_s1, !v_s2)

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-stage query escaper. Every accepted input
// byte is run through a local escaping predictor, and the resulting byte
// sequence is queued. Every output transfer is compared against the oldest
// queued byte. The bench covers the query-syntax set, the exception mask, the
// second-stage mask extremes, random settings, long output back-pressure, and
// drain pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import tsqe_pkg::*;

	localparam int unsigned CycleLimit   = 200000;
	localparam int unsigned HoldCycles   = 80;
	localparam int unsigned SettleCycles = 8;
	localparam int unsigned MaxReports   = 10;
	localparam logic [7:0]  Backslash    = 8'h5C;
	localparam logic [2:0]  RegUnused    = 3'd5;

	// Query-syntax characters; entry i pairs with exception bit i
	localparam logic [7:0] QuerySet [20] = '{
		"+", "-", "&", "|", "!", "(", ")", "{", "}", "[",
		"]", "^", 8'h22, "~", "*", "?", ":", 8'h5C, "/", " "
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} esc_byte_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrW-1:0]     paddr;
	logic [DataW-1:0]     pwdata;
	logic [DataW-1:0]     prdata;
	logic                 pready;

	tsqe_in_if  in_ch ();
	tsqe_out_if out_ch ();

	two_stage_query_escaper u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// Predicted output bytes, oldest first
	esc_byte_t    escaped_bytes [$];
	logic [20:0]  exc_model;
	logic [255:0] second_mask_model;

	int mismatch_count = 0;
	int cycle_count    = 0;
	int burst_left     = 0;
	bit sender_idle_en = 1'b1;
	int hold_asked     = 0;
	int hold_done      = 0;
	int hold_left      = 0;
	int rx_mode        = 0;
	int mode_left      = 0;

	// Clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Stage one: does the byte get a leading backslash
	function automatic bit stage_one_hit(input logic [7:0] c);
		for (int i = 0; i < 20; i++) begin
			if (QuerySet[i] == c)
				return !exc_model[i];
		end
		return 1'b0;
	endfunction

	// Queue the full escaped sequence for one input byte
	function automatic void predict_escape(input logic [7:0] c);
		logic [7:0] first_pass [2];
		logic [7:0] seq [4];
		int         m;
		int         n;
		m = 0;
		n = 0;
		if (stage_one_hit(c)) begin
			first_pass[m] = Backslash;
			m++;
		end
		first_pass[m] = c;
		m++;
		for (int k = 0; k < m; k++) begin
			if (second_mask_model[first_pass[k]]) begin
				seq[n] = Backslash;
				n++;
			end
			seq[n] = first_pass[k];
			n++;
		end
		for (int k = 0; k < n; k++)
			escaped_bytes.push_back('{ch: seq[k], last: (k == n - 1)});
	endfunction

	// Compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		esc_byte_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (escaped_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MaxReports)
					$display("tb: unexpected byte %h last %b at cycle %0d",
						out_ch.out_byte, out_ch.run_last, cycle_count);
			end else begin
				want = escaped_bytes.pop_front();
				if (out_ch.out_byte !== want.ch || out_ch.run_last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MaxReports)
						$display("tb: mismatch at cycle %0d: want %h/%b, got %h/%b",
							cycle_count, want.ch, want.last,
							out_ch.out_byte, out_ch.run_last);
				end
			end
		end
	end

	// Receiver: stall pattern that changes mode now and then, plus long holds
	always @(negedge clk) begin
		if (hold_asked != hold_done) begin
			hold_done = hold_asked;
			hold_left = HoldCycles;
		end
		if (mode_left == 0) begin
			rx_mode   = $urandom_range(0, 2);
			mode_left = $urandom_range(16, 96);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				default: out_ch.ready <= (mode_left % 4 != 0);
			endcase
		end
	end

	// Register write: setup cycle, then access cycle
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			RegExcMask: exc_model = value[20:0];
			RegMask0:   second_mask_model[63:0]    = value;
			RegMask1:   second_mask_model[127:64]  = value;
			RegMask2:   second_mask_model[191:128] = value;
			RegMask3:   second_mask_model[255:192] = value;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [20:0] exc, input logic [63:0] w0,
			input logic [63:0] w1, input logic [63:0] w2, input logic [63:0] w3);
		write_reg(RegExcMask, {43'd0, exc});
		write_reg(RegMask0, w0);
		write_reg(RegMask1, w1);
		write_reg(RegMask2, w2);
		write_reg(RegMask3, w3);
	endtask

	// Send one byte; bursts of random length separated by random gaps
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_idle_en ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predict_escape(b);
	endtask

	// Drop valid and wait until every predicted byte has come out
	task automatic wait_drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (escaped_bytes.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Half syntax characters, half any legal byte
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 1))
			return QuerySet[$urandom_range(0, 19)];
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Reset settings: byte extremes and every syntax character
	task automatic test_syntax_set();
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(8'h80);
		for (int i = 0; i < 20; i++)
			send_byte(QuerySet[i]);
		wait_drain();
	endtask

	// Exception bits suppress stage one; the top bit matches nothing
	task automatic test_exception_mask();
		write_reg(RegExcMask, 64'h1F_FFFF);
		send_byte("+");
		send_byte(8'h22);
		send_byte(8'h5C);
		send_byte(" ");
		wait_drain();
		write_reg(RegExcMask, 64'h10_0000);
		send_byte("+");
		send_byte(8'h22);
		wait_drain();
	endtask

	// A write beyond the last register changes nothing
	task automatic test_unused_register();
		write_reg(RegUnused, '1);
		send_byte("+");
		send_byte(8'h5C);
		wait_drain();
	endtask

	// Second-stage mask fully set, then fully clear
	task automatic test_second_mask_extremes();
		write_all(21'd0, '1, '1, '1, '1);
		send_byte(8'h22);
		send_byte("a");
		send_byte(8'hFF);
		wait_drain();
		write_all(21'h1F_FFFF, '0, '0, '0, '0);
		send_byte(8'h22);
		send_byte(8'h5C);
		send_byte(8'h01);
		wait_drain();
	endtask

	// Random bytes under several settings, extremes among them
	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_all(21'($urandom), rand_word(), rand_word(),
					rand_word(), rand_word());
				1: write_all(21'd0, '1, '1, '1, '1);
				2: write_all(21'h1F_FFFF, '0, '0, '0, '0);
				default: write_all(21'($urandom), rand_word() & rand_word(),
					rand_word() & rand_word(), rand_word(), rand_word());
			endcase
			sender_idle_en = ($urandom_range(0, 3) != 0);
			repeat (45) send_byte(pick_byte());
			wait_drain();
		end
		sender_idle_en = 1'b1;
	endtask

	// Long receiver hold while the sender keeps pushing
	task automatic test_backpressure();
		write_all(21'($urandom), rand_word(), rand_word(), rand_word(), rand_word());
		sender_idle_en = 1'b0;
		hold_asked++;
		repeat (40) send_byte(pick_byte());
		wait_drain();
		sender_idle_en = 1'b1;
	endtask

	// Short runs, each followed by a full drain
	task automatic test_drain_pause();
		repeat (3) begin
			repeat ($urandom_range(5, 12)) send_byte(pick_byte());
			wait_drain();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = 8'h01;
		out_ch.ready  = 1'b0;
		exc_model     = '0;
		second_mask_model = {64'd0, 64'd0, 64'd268435456, 64'd17179869184};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_syntax_set();
		test_exception_mask();
		test_unused_register();
		test_second_mask_extremes();
		test_random_traffic();
		test_backpressure();
		test_drain_pause();

		if (mismatch_count == 0 && escaped_bytes.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tsqe_pkg.sv
hw/rtl/tsqe_in_if.sv
hw/rtl/tsqe_out_if.sv
hw/rtl/two_stage_query_escaper.sv
sim/tb.sv
